[hdl/cbsu_pkg.sv]
// cbsu_pkg: types and constants for the cb-prefix rotate/shift/bit unit
// no dependencies; used by the top level and the testbench
package cbsu_pkg;

  localparam int unsigned DataW  = 8;
  localparam int unsigned AddrW  = 16;
  localparam int unsigned RegIdxW = 3;
  localparam int unsigned NumRegs = 8;
  localparam int unsigned CycleW = 5;

  typedef logic [DataW-1:0]   byte_t;
  typedef logic [RegIdxW-1:0] reg_idx_t;
  typedef logic [CycleW-1:0]  cycles_t;

  // flags kept as {z, n, h, c}
  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  typedef enum logic [1:0] {
    ACT_EXEC       = 2'd0,
    ACT_LOAD_REG   = 2'd1,
    ACT_LOAD_FLAGS = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    GRP_ROT = 2'd0,
    GRP_BIT = 2'd1,
    GRP_RES = 2'd2,
    GRP_SET = 2'd3
  } group_e;

  typedef enum logic [2:0] {
    ROT_RLC  = 3'd0,
    ROT_RRC  = 3'd1,
    ROT_RL   = 3'd2,
    ROT_RR   = 3'd3,
    ROT_SLA  = 3'd4,
    ROT_SRA  = 3'd5,
    ROT_SWAP = 3'd6,
    ROT_SRL  = 3'd7
  } rot_e;

  localparam reg_idx_t MEM_OPERAND = 3'd6;
  localparam reg_idx_t IDX_H       = 3'd4;
  localparam reg_idx_t IDX_L       = 3'd5;

  localparam cycles_t CYC_REG      = 5'd8;
  localparam cycles_t CYC_BIT_MEM  = 5'd12;
  localparam cycles_t CYC_MEM      = 5'd16;
  localparam cycles_t CYC_NONE     = 5'd0;

endpackage

[hdl/cbsu_stream_if.sv]
// cbsu_req_if / cbsu_rsp_if: valid/ready channels of the cb-prefix unit
// no package dependencies
interface cbsu_req_if;
  logic                    valid;
  logic                    ready;
  logic [1:0]              action;
  logic [7:0]              opcode;
  logic [7:0]              mem_rdata;
  logic [2:0]              reg_index;
  logic [7:0]              load_value;

  modport source (output valid, action, opcode, mem_rdata, reg_index, load_value,
                  input ready);
  modport sink   (input valid, action, opcode, mem_rdata, reg_index, load_value,
                  output ready);
endinterface

interface cbsu_rsp_if;
  logic                    valid;
  logic                    ready;
  logic [7:0]              result_value;
  logic                    mem_write;
  logic [15:0]             mem_addr;
  logic                    flag_zero;
  logic                    flag_subtract;
  logic                    flag_half;
  logic                    flag_carry;
  logic [4:0]              cycle_count;

  modport source (output valid, result_value, mem_write, mem_addr, flag_zero,
                  flag_subtract, flag_half, flag_carry, cycle_count,
                  input ready);
  modport sink   (input valid, result_value, mem_write, mem_addr, flag_zero,
                  flag_subtract, flag_half, flag_carry, cycle_count,
                  output ready);
endinterface

[hdl/cb_prefix_bit_shift_unit.sv]
// cb_prefix_bit_shift_unit: a request passes an input register, then a result
// register; throughput one request per cycle while rsp ready is not held low, the
// register file and flags update as a request moves into the result register.
// rst_ni is asynchronous active low: register file and flags clear to zero,
// both pipeline stages empty. depends on cbsu_pkg and cbsu_stream_if
module cb_prefix_bit_shift_unit (
  input  logic     clk_i,
  input  logic     rst_ni,
  cbsu_req_if.sink   req_i,
  cbsu_rsp_if.source rsp_o
);
  import cbsu_pkg::*;

  // input stage
  logic     in_vld_q;
  logic [1:0] act_q;
  byte_t    op_q;
  byte_t    mem_q;
  reg_idx_t ridx_q;
  byte_t    lval_q;

  // architectural state
  byte_t  rf_q [NumRegs];
  byte_t  rf_d [NumRegs];
  flags_t flg_q, flg_d;

  // result stage
  logic    out_vld_q;
  byte_t   res_q, res_d;
  logic    wr_q, wr_d;
  cycles_t cyc_q, cyc_d;
  logic [AddrW-1:0] addr_q;
  flags_t  oflg_q;

  logic out_free, advance;

  assign out_free    = !out_vld_q || rsp_o.ready;
  assign advance     = in_vld_q && out_free;
  assign req_i.ready = !in_vld_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      in_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      act_q  <= req_i.action;
      op_q   <= req_i.opcode;
      mem_q  <= req_i.mem_rdata;
      ridx_q <= req_i.reg_index;
      lval_q <= req_i.load_value;
    end
  end

  always_comb begin
    reg_idx_t sel;
    group_e   grp;
    logic [2:0] bitn;
    logic     indirect;
    byte_t    v;
    byte_t    r;
    logic     co;
    logic     writes;

    sel      = reg_idx_t'(op_q[2:0]);
    grp      = group_e'(op_q[7:6]);
    bitn     = op_q[5:3];
    indirect = (sel == MEM_OPERAND);
    v        = indirect ? mem_q : rf_q[sel];
    r        = '0;
    co       = 1'b0;
    writes   = 1'b1;

    for (int i = 0; i < NumRegs; i++) begin
      rf_d[i] = rf_q[i];
    end
    flg_d = flg_q;
    res_d = '0;
    wr_d  = 1'b0;
    cyc_d = CYC_NONE;

    case (action_e'(act_q))
      ACT_EXEC: begin
        case (grp)
          GRP_ROT: begin
            case (rot_e'(bitn))
              ROT_RLC:  begin co = v[7]; r = {v[6:0], v[7]};      end
              ROT_RRC:  begin co = v[0]; r = {v[0], v[7:1]};      end
              ROT_RL:   begin co = v[7]; r = {v[6:0], flg_q.c};   end
              ROT_RR:   begin co = v[0]; r = {flg_q.c, v[7:1]};   end
              ROT_SLA:  begin co = v[7]; r = {v[6:0], 1'b0};      end
              ROT_SRA:  begin co = v[0]; r = {v[7], v[7:1]};      end
              ROT_SWAP: begin co = 1'b0; r = {v[3:0], v[7:4]};    end
              ROT_SRL:  begin co = v[0]; r = {1'b0, v[7:1]};      end
              default:  begin co = 1'b0; r = v;                   end
            endcase
            flg_d = '{z: (r == '0), n: 1'b0, h: 1'b0, c: co};
          end
          GRP_BIT: begin
            r      = v;
            writes = 1'b0;
            flg_d  = '{z: !v[bitn], n: 1'b0, h: 1'b1, c: flg_q.c};
          end
          GRP_RES: begin
            r = v;
            r[bitn] = 1'b0;
          end
          GRP_SET: begin
            r = v;
            r[bitn] = 1'b1;
          end
          default: r = v;
        endcase
        res_d = r;
        if (indirect) begin
          wr_d  = writes;
          cyc_d = writes ? CYC_MEM : CYC_BIT_MEM;
        end else begin
          if (writes) begin
            rf_d[sel] = r;
          end
          cyc_d = CYC_REG;
        end
      end
      ACT_LOAD_REG: begin
        if (ridx_q != MEM_OPERAND) begin
          rf_d[ridx_q] = lval_q;
        end
      end
      ACT_LOAD_FLAGS: begin
        flg_d = flags_t'(lval_q[7:4]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) begin
        rf_q[i] <= '0;
      end
      flg_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (advance) begin
        for (int i = 0; i < NumRegs; i++) begin
          rf_q[i] <= rf_d[i];
        end
        flg_q <= flg_d;
      end
      if (out_free) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q  <= res_d;
      wr_q   <= wr_d;
      cyc_q  <= cyc_d;
      addr_q <= {rf_d[IDX_H], rf_d[IDX_L]};
      oflg_q <= flg_d;
    end
  end

  assign rsp_o.valid         = out_vld_q;
  assign rsp_o.result_value  = res_q;
  assign rsp_o.mem_write     = wr_q;
  assign rsp_o.mem_addr      = addr_q;
  assign rsp_o.flag_zero     = oflg_q.z;
  assign rsp_o.flag_subtract = oflg_q.n;
  assign rsp_o.flag_half     = oflg_q.h;
  assign rsp_o.flag_carry    = oflg_q.c;
  assign rsp_o.cycle_count   = cyc_q;

endmodule

[bench/cb_prefix_bit_shift_unit_tb.sv]
`timescale 1ns / 100ps
// cb_prefix_bit_shift_unit_tb: self-checking bench, directed then random cb-prefix requests,
// checked against a behavioral copy of the register file and flags
// depends on cbsu_pkg, cbsu_stream_if and cb_prefix_bit_shift_unit
module cb_prefix_bit_shift_unit_tb;
  import cbsu_pkg::*;

  localparam logic [1:0] ActSpare = 2'd3;
  localparam reg_idx_t IdxB = 3'd0;
  localparam reg_idx_t IdxC = 3'd1;
  localparam reg_idx_t IdxD = 3'd2;
  localparam reg_idx_t IdxE = 3'd3;
  localparam reg_idx_t IdxA = 3'd7;
  localparam int unsigned RandomReqs = 1050;
  localparam int unsigned SyncEvery = 300;
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned MaxShown = 10;

  typedef struct packed {
    logic       sync;
    logic [1:0] action;
    byte_t      opcode;
    byte_t      mem_rdata;
    reg_idx_t   reg_index;
    byte_t      load_value;
  } cb_req_t;

  typedef struct packed {
    byte_t            result_value;
    logic             mem_write;
    logic [AddrW-1:0] mem_addr;
    flags_t           flags;
    cycles_t          cycle_count;
  } cb_rsp_t;

  typedef enum logic [1:0] {RDY_ALWAYS, RDY_COIN, RDY_PATTERN, RDY_SPARSE} rdy_mode_e;

  logic    clk_i;
  logic    rst_ni = 1'b0;
  cb_req_t drv_req = '0;
  logic    drv_valid = 1'b0;
  logic    sink_ready = 1'b0;

  cbsu_req_if req_if ();
  cbsu_rsp_if rsp_if ();

  assign req_if.valid      = drv_valid;
  assign req_if.action     = drv_req.action;
  assign req_if.opcode     = drv_req.opcode;
  assign req_if.mem_rdata  = drv_req.mem_rdata;
  assign req_if.reg_index  = drv_req.reg_index;
  assign req_if.load_value = drv_req.load_value;
  assign rsp_if.ready      = sink_ready;

  cb_prefix_bit_shift_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // shadow cpu state
  byte_t  reg_bank [NumRegs];
  flags_t cpu_flags;

  cb_req_t instr_q [$];
  cb_rsp_t due_results [$];

  int unsigned mismatches = 0;
  int unsigned reqs_sent = 0;
  int unsigned results_seen = 0;
  int unsigned mem_hits = 0;
  int unsigned group_hits [4] = '{0, 0, 0, 0};
  int unsigned stall_cycles = 0;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  int unsigned mode_timer = 0;
  rdy_mode_e   ready_mode = RDY_ALWAYS;
  logic [7:0]  ready_pattern = 8'b1101_0110;

  function automatic cb_rsp_t cb_execute(input cb_req_t r);
    cb_rsp_t    o;
    byte_t      src;
    byte_t      res;
    reg_idx_t   sel;
    logic [2:0] bn;
    logic       co;
    logic       writes;
    o = '0;
    o.cycle_count = CYC_NONE;
    res = '0;
    case (r.action)
      ACT_EXEC: begin
        sel = r.opcode[2:0];
        bn = r.opcode[5:3];
        src = (sel == MEM_OPERAND) ? r.mem_rdata : reg_bank[sel];
        writes = 1'b1;
        case (group_e'(r.opcode[7:6]))
          GRP_ROT: begin
            case (rot_e'(bn))
              ROT_RLC: begin co = src[7]; res = {src[6:0], src[7]}; end
              ROT_RRC: begin co = src[0]; res = {src[0], src[7:1]}; end
              ROT_RL: begin co = src[7]; res = {src[6:0], cpu_flags.c}; end
              ROT_RR: begin co = src[0]; res = {cpu_flags.c, src[7:1]}; end
              ROT_SLA: begin co = src[7]; res = {src[6:0], 1'b0}; end
              ROT_SRA: begin co = src[0]; res = {src[7], src[7:1]}; end
              ROT_SWAP: begin co = 1'b0; res = {src[3:0], src[7:4]}; end
              default: begin co = src[0]; res = {1'b0, src[7:1]}; end
            endcase
            cpu_flags.z = (res == '0);
            cpu_flags.n = 1'b0;
            cpu_flags.h = 1'b0;
            cpu_flags.c = co;
          end
          GRP_BIT: begin
            // carry is kept, the operand itself is reported
            cpu_flags.z = ~src[bn];
            cpu_flags.n = 1'b0;
            cpu_flags.h = 1'b1;
            res = src;
            writes = 1'b0;
          end
          GRP_RES: res = src & ~(8'h01 << bn);
          default: res = src | (8'h01 << bn);
        endcase
        o.result_value = res;
        if (sel == MEM_OPERAND) begin
          o.mem_write = writes;
          o.cycle_count = writes ? CYC_MEM : CYC_BIT_MEM;
        end else begin
          if (writes) reg_bank[sel] = res;
          o.cycle_count = CYC_REG;
        end
      end
      ACT_LOAD_REG: begin
        if (r.reg_index != MEM_OPERAND) reg_bank[r.reg_index] = r.load_value;
      end
      ACT_LOAD_FLAGS: cpu_flags = r.load_value[7:4];
      default: ;
    endcase
    o.mem_addr = {reg_bank[IDX_H], reg_bank[IDX_L]};
    o.flags = cpu_flags;
    return o;
  endfunction

  function automatic byte_t cb_op(input group_e grp, input logic [2:0] sub, input reg_idx_t sel);
    return {grp, sub, sel};
  endfunction

  function automatic cb_req_t exec_req(input byte_t op, input byte_t mem);
    cb_req_t r;
    r = '0;
    r.action = ACT_EXEC;
    r.opcode = op;
    r.mem_rdata = mem;
    return r;
  endfunction

  function automatic cb_req_t load_req(input logic [1:0] act, input reg_idx_t idx,
                                       input byte_t val);
    cb_req_t r;
    r = '0;
    r.action = act;
    r.reg_index = idx;
    r.load_value = val;
    return r;
  endfunction

  function automatic cb_req_t rand_req();
    cb_req_t     r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    r.sync = 1'b0;
    r.opcode = 8'($urandom);
    r.mem_rdata = 8'($urandom);
    r.reg_index = 3'($urandom);
    r.load_value = 8'($urandom);
    if (pick < 70) r.action = ACT_EXEC;
    else if (pick < 88) r.action = ACT_LOAD_REG;
    else if (pick < 97) r.action = ACT_LOAD_FLAGS;
    else r.action = ActSpare;
    return r;
  endfunction

  task automatic note_error(input string msg);
    mismatches++;
    if (mismatches <= MaxShown) $display("%0t mismatch: %s", $time, msg);
  endtask

  // request driver: bursts with random gaps, holds a sync request until all results are back
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      drv_valid <= 1'b0;
    end else begin
      if (drv_valid && req_if.ready) begin
        due_results.push_back(cb_execute(drv_req));
        reqs_sent++;
        if (drv_req.action == ACT_EXEC) begin
          group_hits[drv_req.opcode[7:6]]++;
          if (drv_req.opcode[2:0] == MEM_OPERAND) mem_hits++;
        end
      end
      if (!drv_valid || req_if.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          drv_valid <= 1'b0;
        end else if (instr_q.size() == 0 || (instr_q[0].sync && due_results.size() != 0)) begin
          drv_valid <= 1'b0;
        end else begin
          drv_req <= instr_q.pop_front();
          drv_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 7))
              0, 1, 2: gap_left = 0;
              7: gap_left = $urandom_range(20, 40);
              default: gap_left = $urandom_range(1, 6);
            endcase
          end
        end
      end
    end
  end

  // result monitor and receiver stall pattern
  always @(posedge clk_i) begin
    cb_rsp_t got;
    cb_rsp_t want;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        got.result_value = rsp_if.result_value;
        got.mem_write = rsp_if.mem_write;
        got.mem_addr = rsp_if.mem_addr;
        got.flags = {rsp_if.flag_zero, rsp_if.flag_subtract, rsp_if.flag_half,
                     rsp_if.flag_carry};
        got.cycle_count = rsp_if.cycle_count;
        results_seen++;
        if (due_results.size() == 0) begin
          note_error($sformatf("unrequested result val %h wr %b addr %h znhc %b cyc %0d",
                               got.result_value, got.mem_write, got.mem_addr, got.flags,
                               got.cycle_count));
        end else begin
          want = due_results.pop_front();
          if (got !== want)
            note_error($sformatf({"result %0d want val %h wr %b addr %h znhc %b cyc %0d,",
                                  " got val %h wr %b addr %h znhc %b cyc %0d"},
                                 results_seen, want.result_value, want.mem_write,
                                 want.mem_addr, want.flags, want.cycle_count,
                                 got.result_value, got.mem_write, got.mem_addr, got.flags,
                                 got.cycle_count));
        end
      end
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        stall_cycles = 0;
      else if (instr_q.size() != 0 || drv_valid || due_results.size() != 0)
        stall_cycles++;
    end
    if (mode_timer == 0) begin
      ready_mode = rdy_mode_e'($urandom_range(0, 3));
      mode_timer = $urandom_range(20, 80);
    end else begin
      mode_timer--;
    end
    ready_pattern = {ready_pattern[6:0], ready_pattern[7]};
    case (ready_mode)
      RDY_ALWAYS: sink_ready <= 1'b1;
      RDY_COIN: sink_ready <= 1'($urandom_range(0, 1));
      RDY_PATTERN: sink_ready <= ready_pattern[0];
      default: sink_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  initial begin
    while (stall_cycles < StallLimit) @(posedge clk_i);
    $display("cb_prefix_bit_shift_unit_tb: errors");
    $finish;
  end

  initial begin
    cb_req_t r;
    foreach (reg_bank[i]) reg_bank[i] = '0;
    cpu_flags = '0;

    // directed: preset state, every rotate kind, bit/res/set on registers and (HL)
    instr_q.push_back(load_req(ACT_LOAD_FLAGS, IdxB, 8'hF0));
    instr_q.push_back(load_req(ACT_LOAD_REG, IdxB, 8'h80));
    instr_q.push_back(load_req(ACT_LOAD_REG, IdxC, 8'h01));
    instr_q.push_back(load_req(ACT_LOAD_REG, IDX_H, 8'hFF));
    instr_q.push_back(load_req(ACT_LOAD_REG, IDX_L, 8'h00));
    instr_q.push_back(load_req(ACT_LOAD_REG, MEM_OPERAND, 8'hAA));
    instr_q.push_back(load_req(ActSpare, IdxA, 8'h55));
    instr_q.push_back(exec_req(cb_op(GRP_ROT, ROT_RLC, IdxB), 8'h00));
    instr_q.push_back(exec_req(cb_op(GRP_ROT, ROT_RRC, IdxC), 8'h00));
    instr_q.push_back(exec_req(cb_op(GRP_ROT, ROT_RL, IdxD), 8'h00));
    instr_q.push_back(exec_req(cb_op(GRP_ROT, ROT_RR, IdxE), 8'h00));
    instr_q.push_back(load_req(ACT_LOAD_FLAGS, IdxB, 8'h1F));
    instr_q.push_back(exec_req(cb_op(GRP_ROT, ROT_RR, IdxA), 8'h00));
    instr_q.push_back(exec_req(cb_op(GRP_ROT, ROT_SLA, IDX_H), 8'h00));
    instr_q.push_back(exec_req(cb_op(GRP_ROT, ROT_SRA, MEM_OPERAND), 8'h81));
    instr_q.push_back(exec_req(cb_op(GRP_ROT, ROT_SWAP, IDX_L), 8'h00));
    instr_q.push_back(exec_req(cb_op(GRP_ROT, ROT_SWAP, MEM_OPERAND), 8'hA5));
    instr_q.push_back(exec_req(cb_op(GRP_ROT, ROT_SRL, IdxB), 8'h00));
    instr_q.push_back(exec_req(cb_op(GRP_BIT, 3'd7, MEM_OPERAND), 8'h7F));
    instr_q.push_back(exec_req(cb_op(GRP_BIT, 3'd0, IdxC), 8'h00));
    instr_q.push_back(exec_req(cb_op(GRP_RES, 3'd7, MEM_OPERAND), 8'hFF));
    instr_q.push_back(exec_req(cb_op(GRP_SET, 3'd0, IdxA), 8'h00));
    instr_q.push_back(exec_req(cb_op(GRP_SET, 3'd7, MEM_OPERAND), 8'h00));
    instr_q.push_back(exec_req(cb_op(GRP_RES, 3'd0, IdxE), 8'hFF));
    instr_q.push_back(load_req(ACT_LOAD_REG, IdxA, 8'hFF));

    for (int unsigned n = 0; n < RandomReqs; n++) begin
      r = rand_req();
      r.sync = (n % SyncEvery == 0);
      instr_q.push_back(r);
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (instr_q.size() != 0 || drv_valid || due_results.size() != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("covered %0d requests, %0d results: %0d rotate/shift, %0d bit, %0d res, %0d set,",
             reqs_sent, results_seen, group_hits[GRP_ROT], group_hits[GRP_BIT],
             group_hits[GRP_RES], group_hits[GRP_SET]);
    $display("%0d of them on the (HL) operand; %0d mismatches", mem_hits, mismatches);
    if (mismatches == 0)
      $display("cb_prefix_bit_shift_unit_tb: clean");
    else
      $display("cb_prefix_bit_shift_unit_tb: errors");
    $finish;
  end

endmodule
